// ===== rtl/core/rsc_pkg.sv =====
package rsc_pkg;

    localparam int PROCESSES  = 8;
    localparam int RESOURCES  = 4;
    localparam int VALUE_BITS = 8;
    localparam int WORK_BITS  = 12;

    // Fixed widths of the request and result fields.
    localparam int FUNC_W      = 2;
    localparam int PROC_IDX_W  = 3;
    localparam int RES_IDX_W   = 2;
    localparam int FIELD_W     = 8;
    localparam int MASK_W      = 8;
    localparam int OUT_COUNT_W = 4;

    localparam int PROC_W     = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int RES_W      = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
    localparam int CELL_AW    = PROC_W + RES_W;
    localparam int CELL_DEPTH = 1 << CELL_AW;
    localparam int CELL_W     = 2 * VALUE_BITS;
    localparam int COUNT_W    = $clog2(PROCESSES + 1);
    localparam int COUNT_SAT  = (1 << OUT_COUNT_W) - 1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CELL  = 2'd0,
        FUNC_AVAIL = 2'd1,
        FUNC_EVAL  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_APPLY
    } state_t;

    typedef logic [RESOURCES-1:0][VALUE_BITS-1:0] value_vec_t;

    typedef struct packed {
        logic busy;
        logic pending;
    } eval_status_t;

endpackage

// ===== rtl/core/rsc_ram.sv =====
module rsc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/rsc_eval.sv =====
module rsc_eval
    import rsc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  value_vec_t             avail,
    output logic [CELL_AW-1:0]     rd_addr,
    input  logic [CELL_W-1:0]      rd_data,
    output eval_status_t           status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   safe,
    output logic [MASK_W-1:0]      finished_mask,
    output logic [OUT_COUNT_W-1:0] finished_count
);

    localparam logic [RES_W-1:0]  RES_LAST  = RES_W'(RESOURCES - 1);
    localparam logic [PROC_W-1:0] PROC_LAST = PROC_W'(PROCESSES - 1);

    state_t state_reg, state_next;

    logic [PROC_W-1:0]    proc_reg, proc_next;
    logic [RES_W-1:0]     res_reg, res_next;
    logic                 rd_valid_reg, rd_valid_next;
    logic [RES_W-1:0]     rd_res_reg, rd_res_next;
    logic                 pass_reg, pass_next;
    logic                 progress_reg, progress_next;
    logic [PROCESSES-1:0] done_reg, done_next;
    logic [RESOURCES-1:0][WORK_BITS-1:0] work_reg, work_next;
    value_vec_t           held_buf_reg, held_buf_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   safe_reg, safe_next;
    logic [MASK_W-1:0]      mask_reg, mask_next;
    logic [OUT_COUNT_W-1:0] count_reg, count_next;

    logic [VALUE_BITS-1:0] rd_held;
    logic [VALUE_BITS-1:0] rd_claim;
    logic                  advance;
    logic                  made;
    logic                  progress_any;
    logic                  finish;
    logic [COUNT_W-1:0]    done_cnt;
    logic [WORK_BITS:0]    sum;

    assign rd_held  = rd_data[CELL_W-1:VALUE_BITS];
    assign rd_claim = rd_data[VALUE_BITS-1:0];

    // A process is either skipped (already finished) in the scan state or
    // decided in the apply state; both move the sweep to the next process.
    always_comb
    begin
        advance      = (state_reg == ST_APPLY) ||
                       ((state_reg == ST_SCAN) && done_reg[proc_reg]);
        made         = (state_reg == ST_APPLY) && pass_reg;
        progress_any = progress_reg | made;
        finish       = advance && (proc_reg == PROC_LAST) && !progress_any;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (advance)
                begin
                    state_next = finish ? ST_IDLE : ST_SCAN;
                end
                else if (res_reg == RES_LAST)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                state_next = finish ? ST_IDLE : ST_SCAN;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        proc_next      = proc_reg;
        res_next       = res_reg;
        rd_valid_next  = 1'b0;
        rd_res_next    = rd_res_reg;
        pass_next      = pass_reg;
        progress_next  = progress_reg;
        done_next      = done_reg;
        work_next      = work_reg;
        held_buf_next  = held_buf_reg;
        out_valid_next = out_valid_reg;
        safe_next      = safe_reg;
        mask_next      = mask_reg;
        count_next     = count_reg;
        sum            = '0;
        done_cnt       = '0;

        // Read data comes back in the cycle after the address was issued.
        if (rd_valid_reg)
        begin
            held_buf_next[rd_res_reg] = rd_held;
            if ((rd_claim > rd_held) &&
                (WORK_BITS'(rd_claim - rd_held) > work_reg[rd_res_reg]))
            begin
                pass_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < RESOURCES; i++)
                    begin
                        work_next[i] = WORK_BITS'(avail[i]);
                    end
                    done_next     = '0;
                    proc_next     = '0;
                    res_next      = '0;
                    pass_next     = 1'b1;
                    progress_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (!done_reg[proc_reg])
                begin
                    rd_valid_next = 1'b1;
                    rd_res_next   = res_reg;
                    res_next      = (res_reg == RES_LAST) ? '0 : RES_W'(res_reg + 1'b1);
                end
            end
            ST_WAIT:
            begin
            end
            ST_APPLY:
            begin
                if (pass_reg)
                begin
                    done_next[proc_reg] = 1'b1;
                    for (int i = 0; i < RESOURCES; i++)
                    begin
                        sum = {1'b0, work_reg[i]} + (WORK_BITS + 1)'(held_buf_reg[i]);
                        work_next[i] = sum[WORK_BITS] ? '1 : sum[WORK_BITS-1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (advance)
        begin
            res_next  = '0;
            pass_next = 1'b1;
            if (proc_reg == PROC_LAST)
            begin
                proc_next     = '0;
                progress_next = 1'b0;
            end
            else
            begin
                proc_next     = PROC_W'(proc_reg + 1'b1);
                progress_next = progress_any;
            end
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (finish)
        begin
            done_cnt       = COUNT_W'($countones(done_next));
            out_valid_next = 1'b1;
            safe_next      = (done_next == '1);
            count_next     = (int'(done_cnt) > COUNT_SAT) ? OUT_COUNT_W'(COUNT_SAT)
                                                          : OUT_COUNT_W'(done_cnt);
            mask_next      = '0;
            for (int i = 0; i < MASK_W; i++)
            begin
                if (i < PROCESSES)
                begin
                    mask_next[i] = done_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            proc_reg      <= '0;
            res_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            pass_reg      <= 1'b1;
            progress_reg  <= 1'b0;
            done_reg      <= '0;
            work_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            proc_reg      <= proc_next;
            res_reg       <= res_next;
            rd_valid_reg  <= rd_valid_next;
            pass_reg      <= pass_next;
            progress_reg  <= progress_next;
            done_reg      <= done_next;
            work_reg      <= work_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_res_reg   <= rd_res_next;
        held_buf_reg <= held_buf_next;
        safe_reg     <= safe_next;
        mask_reg     <= mask_next;
        count_reg    <= count_next;
    end

    assign rd_addr        = {proc_reg, res_reg};
    assign status.busy    = (state_reg != ST_IDLE);
    assign status.pending = out_valid_reg;
    assign out_valid      = out_valid_reg;
    assign safe           = safe_reg;
    assign finished_mask  = mask_reg;
    assign finished_count = count_reg;

endmodule

// ===== rtl/core/resource_safety_checker.sv =====
// Channel  Handshake             Payload
// in       in_valid / in_ready   func, proc_index, res_index, held_value,
//                                claim_value, avail_value
// out      out_valid / out_ready safe, finished_mask, finished_count
//
// Load requests are accepted back to back while idle. An evaluate request
// sweeps the held/claim memory: it reads every cell of each unfinished
// process, waits for the last read, applies the verdict and skips finished
// ones, for up to PROCESSES passes, plus one final pass that makes no progress.
// Reset clears control state; the tables hold nothing defined until written.
// A pending result blocks only a further evaluate request, not loads.
module resource_safety_checker
    import rsc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [FUNC_W-1:0]      func,
    input  logic [PROC_IDX_W-1:0]  proc_index,
    input  logic [RES_IDX_W-1:0]   res_index,
    input  logic [FIELD_W-1:0]     held_value,
    input  logic [FIELD_W-1:0]     claim_value,
    input  logic [FIELD_W-1:0]     avail_value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   safe,
    output logic [MASK_W-1:0]      finished_mask,
    output logic [OUT_COUNT_W-1:0] finished_count
);

    eval_status_t         status;
    value_vec_t           avail_reg, avail_next;
    logic                 accept;
    logic                 start;
    logic                 cell_we;
    logic [CELL_AW-1:0]   cell_waddr;
    logic [CELL_W-1:0]    cell_wdata;
    logic [CELL_AW-1:0]   cell_raddr;
    logic [CELL_W-1:0]    cell_rdata;

    assign in_ready = !status.busy && !((func == FUNC_EVAL) && status.pending);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        start      = 1'b0;
        cell_we    = 1'b0;
        avail_next = avail_reg;
        cell_waddr = {proc_index[PROC_W-1:0], res_index[RES_W-1:0]};
        cell_wdata = {VALUE_BITS'(held_value), VALUE_BITS'(claim_value)};
        if (accept)
        begin
            unique case (func)
                FUNC_CELL:
                begin
                    cell_we = (int'(proc_index) < PROCESSES) &&
                              (int'(res_index) < RESOURCES);
                end
                FUNC_AVAIL:
                begin
                    if (int'(res_index) < RESOURCES)
                    begin
                        avail_next[res_index[RES_W-1:0]] = VALUE_BITS'(avail_value);
                    end
                end
                FUNC_EVAL:
                begin
                    start = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        avail_reg <= avail_next;
    end

    rsc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_DEPTH)
    ) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    rsc_eval u_eval (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .avail          (avail_reg),
        .rd_addr        (cell_raddr),
        .rd_data        (cell_rdata),
        .status         (status),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .safe           (safe),
        .finished_mask  (finished_mask),
        .finished_count (finished_count)
    );

endmodule

// ===== bench/resource_safety_checker_test.sv =====
`timescale 1ns / 1ps

module resource_safety_checker_test;
    import rsc_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int WORK_MAX = (1 << WORK_BITS) - 1;
    localparam int DRAIN_CYCLES = 600;

    typedef struct packed {
        logic                   safe;
        logic [MASK_W-1:0]      mask;
        logic [OUT_COUNT_W-1:0] count;
    } verdict_t;

    // Mirrors the tables and predicts the verdict of every evaluate request.
    class safety_scoreboard;
        logic [VALUE_BITS-1:0] held_tbl [PROCESSES][RESOURCES];
        logic [VALUE_BITS-1:0] claim_tbl [PROCESSES][RESOURCES];
        logic [VALUE_BITS-1:0] avail_vec [RESOURCES];
        int                    work_vec [RESOURCES];
        logic [PROCESSES-1:0]  done_set;
        verdict_t              pending_verdicts [$];
        int                    mismatches;

        function new();
            for (int p = 0; p < PROCESSES; p++)
                for (int r = 0; r < RESOURCES; r++)
                begin
                    held_tbl[p][r] = '0;
                    claim_tbl[p][r] = '0;
                end
            for (int r = 0; r < RESOURCES; r++)
            begin
                avail_vec[r] = '0;
                work_vec[r] = 0;
            end
            done_set = '0;
            mismatches = 0;
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endtask

        function int outstanding();
            return pending_verdicts.size();
        endfunction

        function void note_request(logic [FUNC_W-1:0] f, logic [PROC_IDX_W-1:0] p,
                                   logic [RES_IDX_W-1:0] r, logic [FIELD_W-1:0] h,
                                   logic [FIELD_W-1:0] c, logic [FIELD_W-1:0] a);
            bit       progress;
            bit       fits;
            int       need;
            int       sum;
            int       n;
            verdict_t v;
            if (f == FUNC_CELL)
            begin
                held_tbl[p][r] = h;
                claim_tbl[p][r] = c;
            end
            else if (f == FUNC_AVAIL)
            begin
                avail_vec[r] = a;
            end
            else if (f == FUNC_EVAL)
            begin
                for (int i = 0; i < RESOURCES; i++)
                    work_vec[i] = int'(avail_vec[i]);
                done_set = '0;
                do
                begin
                    progress = 0;
                    for (int q = 0; q < PROCESSES; q++)
                    begin
                        if (!done_set[q])
                        begin
                            fits = 1;
                            // Held above claim gives a negative need, which always fits.
                            for (int i = 0; i < RESOURCES; i++)
                            begin
                                need = int'(claim_tbl[q][i]) - int'(held_tbl[q][i]);
                                if (need > work_vec[i])
                                    fits = 0;
                            end
                            if (fits)
                            begin
                                done_set[q] = 1'b1;
                                progress = 1;
                                for (int i = 0; i < RESOURCES; i++)
                                begin
                                    sum = work_vec[i] + int'(held_tbl[q][i]);
                                    work_vec[i] = (sum > WORK_MAX) ? WORK_MAX : sum;
                                end
                            end
                        end
                    end
                end
                while (progress);
                n = $countones(done_set);
                v.safe = (n == PROCESSES);
                v.mask = done_set[MASK_W-1:0];
                v.count = OUT_COUNT_W'((n > COUNT_SAT) ? COUNT_SAT : n);
                pending_verdicts.insert(pending_verdicts.size(), v);
            end
        endfunction

        task check_result(logic got_safe, logic [MASK_W-1:0] got_mask,
                          logic [OUT_COUNT_W-1:0] got_count);
            verdict_t want;
            if (pending_verdicts.size() == 0)
            begin
                report($sformatf("result with no evaluate request pending (mask %02h)",
                                 got_mask));
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (got_safe !== want.safe)
                    report($sformatf("safe %0b, expected %0b", got_safe, want.safe));
                if (got_mask !== want.mask)
                    report($sformatf("finished_mask %02h, expected %02h",
                                     got_mask, want.mask));
                if (got_count !== want.count)
                    report($sformatf("finished_count %0d, expected %0d",
                                     got_count, want.count));
            end
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [FUNC_W-1:0]      func = '0;
    logic [PROC_IDX_W-1:0]  proc_index = '0;
    logic [RES_IDX_W-1:0]   res_index = '0;
    logic [FIELD_W-1:0]     held_value = '0;
    logic [FIELD_W-1:0]     claim_value = '0;
    logic [FIELD_W-1:0]     avail_value = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   safe;
    logic [MASK_W-1:0]      finished_mask;
    logic [OUT_COUNT_W-1:0] finished_count;

    safety_scoreboard board;
    bit tx_calm = 0;
    bit rx_calm = 0;
    int stall_left = 0;
    int requests_sent = 0;

    resource_safety_checker uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .proc_index     (proc_index),
        .res_index      (res_index),
        .held_value     (held_value),
        .claim_value    (claim_value),
        .avail_value    (avail_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .safe           (safe),
        .finished_mask  (finished_mask),
        .finished_count (finished_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap(bit calm);
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_value(int mode);
        if (mode == 0)
            return $urandom_range(0, 7);
        if (mode == 1)
            return $urandom_range(0, 31);
        return $urandom_range(0, 255);
    endfunction

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready = 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready = 1'b1;
            stall_left = pick_gap(rx_calm);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(safe, finished_mask, finished_count);
    end

    // Called at a falling edge; returns at a falling edge after the request is taken.
    task automatic send_request(int f, int p, int r, int h, int c, int a);
        int gap;
        in_valid = 1'b1;
        func = FUNC_W'(f);
        proc_index = PROC_IDX_W'(p);
        res_index = RES_IDX_W'(r);
        held_value = FIELD_W'(h);
        claim_value = FIELD_W'(c);
        avail_value = FIELD_W'(a);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_request(func, proc_index, res_index, held_value, claim_value,
                           avail_value);
        if (func != FUNC_UNUSED)
            requests_sent++;
        @(negedge clk);
        gap = pick_gap(tx_calm);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic load_cell(int p, int r, int h, int c);
        send_request(FUNC_CELL, p, r, h, c, $urandom_range(0, 255));
    endtask

    task automatic load_avail(int r, int a);
        send_request(FUNC_AVAIL, $urandom_range(0, 7), r, $urandom_range(0, 255),
                     $urandom_range(0, 255), a);
    endtask

    task automatic evaluate();
        send_request(FUNC_EVAL, $urandom_range(0, 7), $urandom_range(0, 3),
                     $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255));
    endtask

    task automatic wait_for_results();
        in_valid = 1'b0;
        while (board.outstanding() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int mode;
        int n_cells;
        int p;
        int r;
        int c;
        int h;
        bit full;
        board = new();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Every cell and free count is written before the first evaluation.
        for (int i = 0; i < PROCESSES * RESOURCES; i++)
            load_cell(i / RESOURCES, i % RESOURCES, 0, 0);
        for (int i = 0; i < RESOURCES; i++)
            load_avail(i, 0);
        evaluate();

        // A full claim with nothing free blocks the first process.
        load_cell(0, 0, 0, 255);
        evaluate();
        load_avail(0, 255);
        evaluate();
        load_avail(0, 0);
        // Held above claim still lets the last process finish.
        load_cell(7, 3, 255, 0);
        send_request(FUNC_UNUSED, 7, 3, 255, 255, 255);
        evaluate();
        // A later process releases what an earlier one needs, so a second pass is needed.
        load_cell(5, 0, 255, 255);
        evaluate();
        load_cell(3, 1, 255, 255);
        load_avail(3, 255);
        load_avail(2, 128);
        evaluate();
        evaluate();
        load_cell(6, 2, 1, 200);
        load_avail(2, 198);
        evaluate();
        send_request(FUNC_UNUSED, 0, 0, 0, 0, 0);
        load_avail(2, 199);
        evaluate();
        wait_for_results();

        while (requests_sent < 550)
        begin
            mode = $urandom_range(0, 9);
            mode = (mode < 5) ? 0 : (mode < 8) ? 1 : 2;
            full = ($urandom_range(0, 9) == 0);
            n_cells = full ? PROCESSES * RESOURCES : $urandom_range(1, 10);
            for (int i = 0; i < n_cells; i++)
            begin
                p = full ? i / RESOURCES : $urandom_range(0, PROCESSES - 1);
                r = full ? i % RESOURCES : $urandom_range(0, RESOURCES - 1);
                c = pick_value(mode);
                h = ($urandom_range(0, 6) == 0) ? pick_value(mode) : $urandom_range(0, c);
                load_cell(p, r, h, c);
            end
            repeat ($urandom_range(0, 4))
                load_avail($urandom_range(0, RESOURCES - 1), pick_value(mode));
            if ($urandom_range(0, 7) == 0)
                send_request(FUNC_UNUSED, $urandom_range(0, 7), $urandom_range(0, 3),
                             $urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255));
            evaluate();
            if ($urandom_range(0, 5) == 0)
                evaluate();
            if ($urandom_range(0, 11) == 0)
                wait_for_results();
            tx_calm = ($urandom_range(0, 4) == 0);
            rx_calm = ($urandom_range(0, 4) == 0);
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0)
            $display("** resource_safety_checker: PASSED **");
        else
            $display("** resource_safety_checker: FAILED **");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("** resource_safety_checker: FAILED **");
        $finish;
    end

endmodule
